### design/ppid_pkg.sv
// Shared types, constants and helper functions for the positional PID core.
// No dependencies; imported by every module of the block.
package ppid_pkg;

	localparam int GAIN_W  = 32;
	localparam int LIM_W   = 16;
	localparam int VAL_W   = 16;
	localparam int ERR_W   = 18;
	localparam int DIFF_W  = 19;
	localparam int PROD_W  = GAIN_W + ERR_W;
	localparam int DPROD_W = GAIN_W + DIFF_W;
	localparam int WIDE_W  = 54;
	localparam int FRAC_W  = 16;
	localparam int QUOT_W  = WIDE_W - FRAC_W;
	localparam int INT_W   = 17;
	localparam int DRV_W   = 17;
	localparam int IDX_W   = 3;

	localparam logic signed [ERR_W-1:0] ENC_WINDOW = 18'sd4096;
	localparam logic signed [ERR_W-1:0] ENC_SHIFT  = 18'sd8190;
	localparam logic signed [ERR_W-1:0] DEG_WINDOW = 18'sd180;
	localparam logic signed [ERR_W-1:0] DEG_SHIFT  = 18'sd360;

	typedef enum logic [1:0] {
		MODE_ENCODER = 2'd0,
		MODE_DEGREE  = 2'd1,
		MODE_NOWRAP  = 2'd2
	} wrap_mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_LIMIT = 3'd3,
		REG_OUT_LIMIT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop;
		logic signed [GAIN_W-1:0] integ;
		logic signed [GAIN_W-1:0] deriv;
	} gains_t;

	typedef struct packed {
		logic [LIM_W-1:0] integ;
		logic [LIM_W-1:0] out;
	} limits_t;

	typedef struct packed {
		logic signed [PROD_W-1:0]  prop;
		logic signed [PROD_W-1:0]  integ;
		logic signed [DPROD_W-1:0] deriv;
	} prod_t;

	// Q.16 to integer, rounding toward zero.
	function automatic logic signed [QUOT_W-1:0] trunc_frac(input logic signed [WIDE_W-1:0] v);
		logic signed [QUOT_W-1:0] q;
		begin
			q = v[WIDE_W-1:FRAC_W];
			if (v[WIDE_W-1] && (v[FRAC_W-1:0] != '0)) begin
				q = q + QUOT_W'(1);
			end
			return q;
		end
	endfunction

	// Symmetric clamp of a wide integer to +-lim.
	function automatic logic signed [INT_W-1:0] clamp_sym(input logic signed [QUOT_W-1:0] v,
			input logic [LIM_W-1:0] lim);
		logic signed [QUOT_W-1:0] hi;
		logic signed [QUOT_W-1:0] lo;
		logic signed [QUOT_W-1:0] r;
		begin
			hi = $signed({{(QUOT_W-LIM_W){1'b0}}, lim});
			lo = -hi;
			if (v > hi) begin
				r = hi;
			end else if (v < lo) begin
				r = lo;
			end else begin
				r = v;
			end
			return r[INT_W-1:0];
		end
	endfunction

endpackage

### design/ppid_front.sv
// Error stage: wrap correction, error difference and the three gain products.
// Depends on ppid_pkg; holds the previous-error state.
module ppid_front
	import ppid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [1:0]              mode,
	input  logic signed [VAL_W-1:0] target,
	input  logic signed [VAL_W-1:0] measured,
	input  gains_t                  gains,
	output prod_t                   prod
);

	logic signed [ERR_W-1:0]   diff;
	logic signed [ERR_W-1:0]   err;
	logic signed [ERR_W-1:0]   last_error_q;
	logic signed [DIFF_W-1:0]  err_delta;
	logic signed [PROD_W-1:0]  prop_p;
	logic signed [PROD_W-1:0]  integ_p;
	logic signed [DPROD_W-1:0] deriv_p;
	prod_t                     prod_s2;

	assign diff = ERR_W'(target) - ERR_W'(measured);

	always_comb begin
		err = diff;
		case (mode)
			MODE_ENCODER: begin
				if (diff > ENC_WINDOW) begin
					err = diff - ENC_SHIFT;
				end else if (diff < -ENC_WINDOW) begin
					err = diff + ENC_SHIFT;
				end
			end
			MODE_DEGREE: begin
				if (diff > DEG_WINDOW) begin
					err = diff - DEG_SHIFT;
				end else if (diff < -DEG_WINDOW) begin
					err = diff + DEG_SHIFT;
				end
			end
			default: begin
				err = diff;
			end
		endcase
	end

	assign err_delta = DIFF_W'(err) - DIFF_W'(last_error_q);
	assign prop_p    = PROD_W'(gains.prop) * PROD_W'(err);
	assign integ_p   = PROD_W'(gains.integ) * PROD_W'(err);
	assign deriv_p   = DPROD_W'(gains.deriv) * DPROD_W'(err_delta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
		end else if (load) begin
			last_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2.prop  <= prop_p;
			prod_s2.integ <= integ_p;
			prod_s2.deriv <= deriv_p;
		end
	end

	assign prod = prod_s2;

endmodule

### design/ppid_back.sv
// Accumulate stage: integral update and clamp, term sum, output clamp.
// Depends on ppid_pkg; holds the integral state and the result register.
module ppid_back
	import ppid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  prod_t                   prod,
	input  limits_t                 limits,
	output logic signed [DRV_W-1:0] drive
);

	logic signed [INT_W-1:0]  integral_q;
	logic signed [WIDE_W-1:0] acc;
	logic signed [INT_W-1:0]  integral_nx;
	logic signed [WIDE_W-1:0] sum;
	logic signed [DRV_W-1:0]  drive_q;

	assign acc = {{(WIDE_W-INT_W-FRAC_W){integral_q[INT_W-1]}}, integral_q, {FRAC_W{1'b0}}}
		+ WIDE_W'(prod.integ);
	assign integral_nx = clamp_sym(trunc_frac(acc), limits.integ);

	assign sum = WIDE_W'(prod.prop) + WIDE_W'(prod.deriv)
		+ {{(WIDE_W-INT_W-FRAC_W){integral_nx[INT_W-1]}}, integral_nx, {FRAC_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (load) begin
			integral_q <= integral_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drive_q <= clamp_sym(trunc_frac(sum), limits.out);
		end
	end

	assign drive = drive_q;

endmodule

### design/positional_pid_with_angle_wrap_core.sv
// Positional PID controller with wrap correction: top level with handshake and registers.
// Throughput: one beat per cycle unless the output stalls (3 registers in the pipeline).
// The gain products are registered ahead of the integral loop.
// Reset (arst_n low, asynchronous): gains, limits, previous error and integral clear to zero,
// and all pipeline stages empty. Depends on ppid_pkg, ppid_front and ppid_back.
module positional_pid_with_angle_wrap_core
	import ppid_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic signed [VAL_W-1:0]  target,
	input  logic signed [VAL_W-1:0]  measured,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DRV_W-1:0]  drive
);

	// Configuration registers. Writes to indexes past the last register are dropped.
	gains_t  gains_q;
	limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q  <= '0;
			limits_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PROP_GAIN:   gains_q.prop   <= cfg_data;
				REG_INTEG_GAIN:  gains_q.integ  <= cfg_data;
				REG_DERIV_GAIN:  gains_q.deriv  <= cfg_data;
				REG_INTEG_LIMIT: limits_q.integ <= cfg_data[LIM_W-1:0];
				REG_OUT_LIMIT:   limits_q.out   <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Three-stage pipeline: input register (s1), product register (s2) and the
	// result register inside the accumulate stage. Each stage moves forward when
	// the stage after it is empty or is itself moving, so bubbles fill in even
	// while a finished result waits on the output side.
	logic                    v_s1;
	logic                    v_s2;
	logic                    out_v_q;
	logic                    adv1;
	logic                    adv2;
	logic [1:0]              mode_s1;
	logic signed [VAL_W-1:0] target_s1;
	logic signed [VAL_W-1:0] measured_s1;
	prod_t                   prod;

	assign adv2     = v_s2 && (!out_v_q || out_ready);
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign in_ready = !v_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (!v_s2 || adv2) begin
				v_s2 <= adv1;
			end
			if (!out_v_q || out_ready) begin
				out_v_q <= adv2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1     <= mode;
			target_s1   <= target;
			measured_s1 <= measured;
		end
	end

	// The previous error advances with each beat leaving s1; the integral
	// advances with each beat leaving s2, so both see beats in arrival order.
	ppid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv1),
		.mode     (mode_s1),
		.target   (target_s1),
		.measured (measured_s1),
		.gains    (gains_q),
		.prod     (prod)
	);

	ppid_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv2),
		.prod   (prod),
		.limits (limits_q),
		.drive  (drive)
	);

	assign out_valid = out_v_q;

	// A beat leaving the product stage must land in the result register.
	a_adv2_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> out_v_q)
		else $error("result register not loaded after accumulate stage advanced");

	// A beat in s2 stays there while the output is stalled.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && out_v_q && !out_ready) |=> v_s2)
		else $error("product stage dropped a beat during output stall");

	// An accepted input beat always occupies s1 on the next cycle.
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted input beat missing from input stage");

	// s1 only advances into a free or draining s2.
	a_s1_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |-> (!v_s2 || adv2))
		else $error("input stage advanced into an occupied product stage");

endmodule

### bench/tb_top.sv
// Self-checking bench for the positional PID core with wrap correction.
// Needs ppid_pkg and positional_pid_with_angle_wrap_core; drives both handshakes and the
// register port, and predicts every drive value with its own integer model of the loop.
`timescale 1ns / 100ps

module tb_top;
	import ppid_pkg::*;

	// Mode 3 is not named in the package; the core treats it as no wrap.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// Indexes above the last register are decoded to nothing.
	localparam logic [IDX_W-1:0] REG_SPARE_FIRST = IDX_W'(REG_OUT_LIMIT + 1);
	localparam int REG_SPARE_LAST = (1 << IDX_W) - 1;

	localparam longint Q_ONE = 64'sd65536;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int RAND_PHASES = 10;
	localparam int BEATS_PER_PHASE = 145;
	localparam int HOLD_PHASE = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = '0;
	logic signed [VAL_W-1:0] target = '0;
	logic signed [VAL_W-1:0] measured = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DRV_W-1:0] drive;

	positional_pid_with_angle_wrap_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.target    (target),
		.measured  (measured),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	// 8 ns clock, four high and four low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A hard ceiling several times above the slowest legal run.
	initial begin
		#3200000;
		$display("simulation failed");
		$finish;
	end

	// Predictor state: a private copy of the registers and of the loop memory.
	// Everything is held in 64-bit integers so no intermediate can overflow.
	longint gain_p = 0;
	longint gain_i = 0;
	longint gain_d = 0;
	longint lim_i = 0;
	longint lim_o = 0;
	longint err_prev = 0;
	longint integ_state = 0;

	// Drive values still owed by the core, oldest first.
	logic signed [DRV_W-1:0] drive_due [$];

	int mismatches = 0;
	bit stall_on = 1'b1;  // when clear, neither side inserts idle cycles
	bit hold_req = 1'b0;  // asks the receiver for one long hold-off
	bit dirty = 1'b0;     // beats went in since the last drain

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint bound_sym(input longint v, input longint lim);
		if (v < -lim) begin
			return -lim;
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

	// Outside the window the difference is folded back by the shift amount.
	function automatic longint wrap_error(input longint d, input longint win, input longint sh);
		if (d > win) begin
			return d - sh;
		end
		if (d < -win) begin
			return d + sh;
		end
		return d;
	endfunction

	// One controller step. The integral is updated first and feeds the same step's sum;
	// integer division in SystemVerilog truncates toward zero, as the core must.
	function automatic logic signed [DRV_W-1:0] compute_drive(input logic [1:0] m,
			input logic signed [VAL_W-1:0] t, input logic signed [VAL_W-1:0] meas);
		longint diff;
		longint err;
		longint acc;
		longint sum;
		longint drv;
		diff = longint'(t) - longint'(meas);
		if (m == MODE_ENCODER) begin
			err = wrap_error(diff, ENC_WINDOW, ENC_SHIFT);
		end else if (m == MODE_DEGREE) begin
			err = wrap_error(diff, DEG_WINDOW, DEG_SHIFT);
		end else begin
			err = diff;
		end
		acc = integ_state * Q_ONE + gain_i * err;
		integ_state = bound_sym(acc / Q_ONE, lim_i);
		sum = gain_p * err + gain_d * (err - err_prev) + integ_state * Q_ONE;
		drv = bound_sym(sum / Q_ONE, lim_o);
		err_prev = err;
		return drv[DRV_W-1:0];
	endfunction

	// Gains are signed 32-bit; limits take only the low half of the data word.
	function automatic void apply_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		case (idx)
			REG_PROP_GAIN: begin
				gain_p = longint'($signed(data));
			end
			REG_INTEG_GAIN: begin
				gain_i = longint'($signed(data));
			end
			REG_DERIV_GAIN: begin
				gain_d = longint'($signed(data));
			end
			REG_INTEG_LIMIT: begin
				lim_i = longint'(data[LIM_W-1:0]);
			end
			REG_OUT_LIMIT: begin
				lim_o = longint'(data[LIM_W-1:0]);
			end
			default: begin
			end
		endcase
	endfunction

	// Lower valid right after the last accepted beat, wait for every owed result, then
	// give the pipeline a few spare cycles so a register write lands on an idle core.
	task automatic drain_pipe();
		@(negedge clk) in_valid <= 1'b0;
		while (drive_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		dirty = 1'b0;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		if (dirty) begin
			drain_pipe();
		end
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_write(idx, data);
		@(negedge clk) cfg_wr_en <= 1'b0;
	endtask

	// Offer one beat after a random gap and hold it until it is taken. With no gap the
	// next payload replaces the previous one at the same falling edge, valid staying high.
	task automatic send_beat(input logic [1:0] m, input logic signed [VAL_W-1:0] t,
			input logic signed [VAL_W-1:0] meas, input bit typed,
			input logic signed [DRV_W-1:0] typed_drive);
		int gap;
		logic signed [DRV_W-1:0] pred;
		gap = stall_on ? $urandom_range(0, 17) : 0;
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		target <= t;
		measured <= meas;
		do begin
			@(posedge clk);
		end while (in_ready !== 1'b1);
		// The predictor always steps, so hand-typed rows keep its state in line too.
		pred = compute_drive(m, t, meas);
		drive_due.push_back(typed ? typed_drive : pred);
		dirty = 1'b1;
	endtask

	// Directed stimulus table: register writes and beats in order, some with the
	// expected drive written in by hand.
	typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [IDX_W-1:0] idx;
		logic [GAIN_W-1:0] data;
		logic [1:0] m;
		logic signed [VAL_W-1:0] t;
		logic signed [VAL_W-1:0] meas;
		bit typed;
		logic signed [DRV_W-1:0] want;
	} stim_row_t;

	stim_row_t stim_table [$];

	function automatic void add_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		stim_row_t r;
		r = '{ROW_WRITE, idx, data, 2'd0, 16'sd0, 16'sd0, 1'b0, 17'sd0};
		stim_table.push_back(r);
	endfunction

	function automatic void add_beat(input logic [1:0] m, input logic signed [VAL_W-1:0] t,
			input logic signed [VAL_W-1:0] meas, input bit typed,
			input logic signed [DRV_W-1:0] want);
		stim_row_t r;
		r = '{ROW_BEAT, REG_PROP_GAIN, 32'd0, m, t, meas, typed, want};
		stim_table.push_back(r);
	endfunction

	function automatic logic signed [VAL_W-1:0] extreme_val();
		case ($urandom_range(0, 2))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'sh0000;
		endcase
	endfunction

	// Gains mix the two extremes, zero, small values near unity, tiny fractions and
	// full-range words, each negated half the time.
	function automatic logic [GAIN_W-1:0] pick_gain();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(0, 5))
			0: g = '0;
			1: g = 32'h7FFF_FFFF;
			2: g = 32'h8000_0000;
			3: g = $urandom_range(0, 32'h0003_0000);
			4: g = $urandom_range(0, 32'h0000_1FFF);
			default: g = $urandom;
		endcase
		if ($urandom_range(0, 1) == 1) begin
			g = -g;
		end
		return g;
	endfunction

	// Limits include zero and the maximum; the unused upper half sometimes carries junk.
	function automatic logic [GAIN_W-1:0] pick_limit();
		logic [LIM_W-1:0] lim;
		logic [LIM_W-1:0] upper;
		case ($urandom_range(0, 3))
			0: lim = '0;
			1: lim = 16'hFFFF;
			2: lim = LIM_W'($urandom_range(0, 65535));
			default: lim = LIM_W'($urandom_range(1, 500));
		endcase
		upper = ($urandom_range(0, 1) == 1) ? LIM_W'($urandom) : '0;
		return {upper, lim};
	endfunction

	// Random beat: errors close to the wrap windows, small tracking errors that let the
	// integral build up, full-range noise and rail values, each equally often.
	task automatic gen_beat(output logic [1:0] m, output logic signed [VAL_W-1:0] t,
			output logic signed [VAL_W-1:0] meas);
		int r;
		int base;
		int delta;
		int win;
		r = $urandom_range(0, 9);
		m = (r < 3) ? MODE_ENCODER : (r < 6) ? MODE_DEGREE : (r < 9) ? MODE_NOWRAP : MODE_SPARE;
		case ($urandom_range(0, 3))
			0: begin
				t = VAL_W'($urandom);
				meas = VAL_W'($urandom);
			end
			1: begin
				win = (m == MODE_DEGREE) ? int'(DEG_WINDOW) : int'(ENC_WINDOW);
				base = int'($urandom_range(0, 20000)) - 10000;
				delta = win + int'($urandom_range(0, 6)) - 3;
				if ($urandom_range(0, 1) == 1) begin
					delta = -delta;
				end
				t = VAL_W'(base + delta);
				meas = VAL_W'(base);
			end
			2: begin
				base = int'($urandom_range(0, 800)) - 400;
				t = VAL_W'(base + int'($urandom_range(0, 100)) - 50);
				meas = VAL_W'(base);
			end
			default: begin
				t = extreme_val();
				meas = extreme_val();
			end
		endcase
	endtask

	// Receiver: a random number of idle cycles before each result, and once, a long
	// hold-off while the sender keeps offering, so the core fills and drops in_ready.
	initial begin
		int w;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk) out_ready <= 1'b0;
			end
			w = stall_on ? $urandom_range(0, 17) : 0;
			repeat (w) @(negedge clk) out_ready <= 1'b0;
			@(negedge clk) out_ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (out_valid !== 1'b1);
		end
	end

	// Result checker: every accepted output beat is matched against the oldest owed value.
	always @(posedge clk) begin
		logic signed [DRV_W-1:0] want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (drive_due.size() == 0) begin
				report_mismatch($sformatf("unexpected output beat, drive %0d", drive));
			end else begin
				want = drive_due.pop_front();
				if (drive !== want) begin
					report_mismatch($sformatf("drive got %0d want %0d", drive, want));
				end
			end
		end
	end

	initial begin
		int ph;
		logic [1:0] m;
		logic signed [VAL_W-1:0] t;
		logic signed [VAL_W-1:0] meas;

		// Straight after reset every gain and limit is zero, so the drive must be zero.
		add_beat(MODE_ENCODER, 32767, -32768, 1'b1, 0);
		add_beat(MODE_SPARE, -32768, 32767, 1'b1, 0);
		// Unity proportional gain and wide limits: the drive reads back the wrapped error.
		add_write(REG_PROP_GAIN, 32'h0001_0000);
		add_write(REG_INTEG_GAIN, 32'h0000_0000);
		add_write(REG_DERIV_GAIN, 32'h0000_0000);
		add_write(REG_INTEG_LIMIT, 32'h0000_FFFF);
		add_write(REG_OUT_LIMIT, 32'h0000_FFFF);
		add_beat(MODE_NOWRAP, 32767, -32768, 1'b1, 65535);
		add_beat(MODE_NOWRAP, -32768, 32767, 1'b1, -65535);
		add_beat(MODE_ENCODER, 5000, 0, 1'b1, -3190);
		add_beat(MODE_ENCODER, 4096, 0, 1'b1, 4096);
		add_beat(MODE_ENCODER, -4097, 0, 1'b1, 4093);
		add_beat(MODE_ENCODER, 4097, 0, 1'b1, -4093);
		add_beat(MODE_ENCODER, -32768, 32767, 1'b1, -57345);
		add_beat(MODE_ENCODER, 32767, -32768, 1'b1, 57345);
		add_beat(MODE_DEGREE, 181, 0, 1'b1, -179);
		add_beat(MODE_DEGREE, 180, 0, 1'b1, 180);
		add_beat(MODE_DEGREE, -181, 0, 1'b1, 179);
		add_beat(MODE_DEGREE, -180, 0, 1'b1, -180);
		add_beat(MODE_DEGREE, 32767, -32768, 1'b1, 65175);
		// The unused mode code must behave as no wrap.
		add_beat(MODE_SPARE, 1000, -1000, 1'b1, 2000);
		// A zero output limit pins the drive to zero; a small one clips both ways.
		add_write(REG_OUT_LIMIT, 32'h0000_0000);
		add_beat(MODE_NOWRAP, 500, 0, 1'b1, 0);
		add_write(REG_OUT_LIMIT, 32'h0000_0064);
		add_beat(MODE_NOWRAP, 500, 0, 1'b1, 100);
		add_beat(MODE_NOWRAP, -500, 0, 1'b1, -100);
		// A zero integral limit keeps the integral at zero whatever its gain.
		add_write(REG_INTEG_GAIN, 32'h0001_0000);
		add_write(REG_INTEG_LIMIT, 32'h0000_0000);
		add_write(REG_PROP_GAIN, 32'h0000_0000);
		add_beat(MODE_NOWRAP, 300, 0, 1'b1, 0);
		// A gain of minus one half on an odd error: the quotient rounds toward zero.
		add_write(REG_PROP_GAIN, 32'hFFFF_8000);
		add_beat(MODE_NOWRAP, 3, 0, 1'b1, -1);
		add_beat(MODE_NOWRAP, -3, 0, 1'b1, 1);
		// Extreme gains with full-scale error steps, left to the predictor.
		add_write(REG_INTEG_LIMIT, 32'h0000_FFFF);
		add_write(REG_OUT_LIMIT, 32'h0000_FFFF);
		add_write(REG_DERIV_GAIN, 32'h7FFF_FFFF);
		add_write(REG_PROP_GAIN, 32'h8000_0000);
		add_write(REG_INTEG_GAIN, 32'h8000_0000);
		add_beat(MODE_NOWRAP, 32767, -32768, 1'b0, 0);
		add_beat(MODE_NOWRAP, -32768, 32767, 1'b0, 0);
		add_beat(MODE_ENCODER, 100, 50, 1'b0, 0);

		// Reset is released on a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_WRITE) begin
				write_reg(stim_table[i].idx, stim_table[i].data);
			end else begin
				send_beat(stim_table[i].m, stim_table[i].t, stim_table[i].meas,
					stim_table[i].typed, stim_table[i].want);
			end
		end

		// Random phases: fresh settings each time, including a write to an unused index,
		// then a run of beats. Some phases go flat out with no idle cycles on either side.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			write_reg(REG_PROP_GAIN, pick_gain());
			write_reg(REG_INTEG_GAIN, pick_gain());
			write_reg(REG_DERIV_GAIN, pick_gain());
			write_reg(REG_INTEG_LIMIT, pick_limit());
			write_reg(REG_OUT_LIMIT, pick_limit());
			write_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
			stall_on = (ph != HOLD_PHASE) && (ph % 4 != 3);
			if (ph == HOLD_PHASE) begin
				hold_req = 1'b1;
			end
			repeat (BEATS_PER_PHASE) begin
				gen_beat(m, t, meas);
				send_beat(m, t, meas, 1'b0, '0);
			end
		end

		// Let the last results drain, then a few more cycles to catch any extra beat.
		@(negedge clk) in_valid <= 1'b0;
		while (drive_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && drive_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
